[sv/utra_pkg.sv]
// Package for the radix-to-ASCII converter: widths, character constants,
// radix clamping, digit encoding and the controller/datapath command types.
// No dependencies.
package utra_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;
    localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;  // '0'
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h61;  // 'a'

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take a new value, clear count and remainder
        logic step;   // one restoring-division bit
        logic store;  // push remainder into the digit buffer
        logic read;   // fetch the next digit, most significant first
        logic emit;   // load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic bit_last;  // current step is the final bit of a division
        logic quo_zero;  // quotient is zero, all digits produced
        logic cnt_zero;  // no digits left in the buffer
        logic out_free;  // output register can take a digit
    } t_dp_sts;

    // Out-of-range register codes fold onto the nearest legal radix
    function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > DIGIT_NINE) begin
            res = ASCII_A + CHAR_W'(d - DIGIT_TEN);
        end else begin
            res = ASCII_ZERO + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

[sv/utra_if.sv]
// Valid/ready channel interfaces for the radix-to-ASCII converter:
// the value input and the digit output. Depends on utra_pkg.
interface utra_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface utra_out_if;
    logic                         valid;
    logic                         ready;
    logic [utra_pkg::CHAR_W-1:0]  digit_char;
    logic                         last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

[sv/unsigned_to_radix_ascii_top.sv]
// Top level of the unsigned-to-radix ASCII converter: joins controller and
// datapath to the channel interfaces. Depends on utra_pkg, utra_if, utra_ctrl, utra_dp.
//
//  channel  dir  handshake       payload
//  i_in     in   valid/ready     value [VALUE_WIDTH-1:0]
//  o_out    out  valid/ready     digit_char [6:0], last_digit
//  cfg      in   i_cfg_we        i_cfg_wdata [5:0] (radix)
//
// One item at a time. Each digit comes from the one-bit-per-cycle restoring
// divider and is stored in the digit buffer; once all digits are produced,
// they are read back and emitted, most significant first. A new item is taken
// while the last digit of the previous one still waits in the output register.
// Output stalls hold the emit step. Reset is synchronous and active low; the
// radix returns to 10 and no memory clearing pass is needed.
module unsigned_to_radix_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [utra_pkg::RADIX_W-1:0]   i_cfg_wdata,
    utra_in_if.sink                        i_in,
    utra_out_if.source                     o_out
);
    import utra_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_in.ready = in_ready;

    // Sequencer: load, divide per digit, then drain the digit buffer
    utra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Divider, digit buffer and output register
    utra_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_value      (i_in.value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_digit_char (o_out.digit_char),
        .o_last_digit (o_out.last_digit)
    );

endmodule

[sv/utra_ctrl.sv]
// Controller for the radix-to-ASCII converter: one-hot state machine that
// sequences load, division, digit store and digit emission. Depends on utra_pkg.
module utra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  utra_pkg::t_dp_sts i_sts,
    output utra_pkg::t_dp_cmd o_cmd
);
    import utra_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_STORE = 5'b00100,
        S_READ  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.bit_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_sts.quo_zero ? S_READ : S_DIV;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.cnt_zero ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/utra_dp.sv]
// Datapath for the radix-to-ASCII converter: radix register, bit-serial
// restoring divider, digit buffer memory and output register. Depends on utra_pkg.
module utra_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [utra_pkg::RADIX_W-1:0]   i_cfg_wdata,
    input  logic [VALUE_WIDTH-1:0]         i_value,
    input  utra_pkg::t_dp_cmd              i_cmd,
    output utra_pkg::t_dp_sts              o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [utra_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last_digit
);
    import utra_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int BIT_W = $clog2(VALUE_WIDTH);

    logic [RADIX_W-1:0]     r_radix;
    logic [RADIX_W-1:0]     r_rdx;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [RADIX_W-1:0]     r_rem;
    logic [BIT_W-1:0]       r_bit;
    logic [CNT_W-1:0]       r_cnt;
    logic [RADIX_W-1:0]     r_rd_digit;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;

    logic [RADIX_W-1:0]     mem [VALUE_WIDTH];

    logic [RADIX_W:0]       trial;
    logic                   trial_ge;
    logic [RADIX_W-1:0]     n_rem;
    logic [CNT_W-1:0]       cnt_dec;
    logic                   out_free;

    // Restoring division: shift in next dividend bit, subtract if it fits
    assign trial    = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign trial_ge = (trial >= {1'b0, r_rdx});
    assign n_rem    = trial_ge ? RADIX_W'(trial - {1'b0, r_rdx}) : trial[RADIX_W-1:0];
    assign cnt_dec  = r_cnt - CNT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.bit_last = (r_bit == BIT_W'(VALUE_WIDTH - 1));
    assign o_sts.quo_zero = (r_quo == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.store) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (i_cmd.read) begin
            r_cnt <= cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdx <= radix_clamp(r_radix);
            r_quo <= i_value;
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], trial_ge};
            r_rem <= n_rem;
            r_bit <= r_bit + BIT_W'(1);
        end else if (i_cmd.store) begin
            r_rem <= '0;
            r_bit <= '0;
        end
    end

    // Digit buffer, filled least significant first, drained in reverse
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mem[r_cnt[IDX_W-1:0]] <= r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_digit <= mem[cnt_dec[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= digit_ascii(r_rd_digit);
            r_out_last <= (r_cnt == '0);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_cnt != CNT_W'(VALUE_WIDTH)))
        else $error("digit buffer overrun");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |-> (r_cnt != '0))
        else $error("read from empty digit buffer");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("output register overwritten");

    a_last_then_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_cnt == '0) |=> (r_cnt == '0 && o_last_digit))
        else $error("last digit flag out of step with buffer");

endmodule
